// ----- rtl/macp_pkg.sv -----
package macp_pkg;

   // parse context, one-hot
   typedef enum logic [9:0] {
      CX_PROTOCOL = 10'b00_0000_0001,
      CX_ADDR     = 10'b00_0000_0010,
      CX_ROLE     = 10'b00_0000_0100,
      CX_HOST     = 10'b00_0000_1000,
      CX_NODE     = 10'b00_0001_0000,
      CX_TASK     = 10'b00_0010_0000,
      CX_VPATH    = 10'b00_0100_0000,
      CX_END      = 10'b00_1000_0000,
      CX_COLON2   = 10'b01_0000_0000,
      CX_SLASH2   = 10'b10_0000_0000
   } ctx_type;

   localparam logic [2:0] TAG_NONE     = 3'd0;
   localparam logic [2:0] TAG_PROTOCOL = 3'd1;
   localparam logic [2:0] TAG_ROLE     = 3'd2;
   localparam logic [2:0] TAG_HOST     = 3'd3;
   localparam logic [2:0] TAG_NODE     = 3'd4;
   localparam logic [2:0] TAG_TASK     = 3'd5;
   localparam logic [2:0] TAG_PATH     = 3'd6;

   localparam logic [1:0] FMT_DEFAULT = 2'd0;
   localparam logic [1:0] FMT_ROLE    = 2'd1;
   localparam logic [1:0] FMT_VPATH   = 2'd2;
   localparam logic [1:0] FMT_RAW     = 2'd3;

   localparam logic [7:0] CH_AT        = 8'h40;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_COLON     = 8'h3a;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_PRINT_LO  = 8'd32;
   localparam logic [7:0] CH_PRINT_END = 8'd127;

   typedef struct packed {
      ctx_type ctx;
      logic    task_empty;
      logic    role_seen;
      logic    path_seen;
      logic    only_protocol;
      logic    failed;
   } macp_state_type;

   typedef struct packed {
      logic [2:0] field_tag;
      logic       char_error;
      logic       format_valid;
      logic [1:0] addr_format;
   } macp_result_type;

   localparam macp_state_type STATE_RESET = '{
      ctx:           CX_PROTOCOL,
      task_empty:    1'b1,
      role_seen:     1'b0,
      path_seen:     1'b0,
      only_protocol: 1'b1,
      failed:        1'b0
   };

endpackage

// ----- rtl/macp_step.sv -----
module macp_step (
   input  macp_pkg::macp_state_type  cur,
   input  logic [7:0]                ch,
   input  logic                      is_last,
   output macp_pkg::macp_state_type  nxt,
   output macp_pkg::macp_result_type res
);
   import macp_pkg::*;

   macp_state_type  st;
   logic [2:0]      tag;
   logic            err;

   always_comb begin
      st  = cur;
      tag = TAG_NONE;
      err = 1'b0;
      if (!cur.failed) begin
         if (ch < CH_PRINT_LO || ch >= CH_PRINT_END) begin
            err = 1'b1;
         end else if (cur.ctx == CX_COLON2) begin
            st.only_protocol = 1'b0;
            if (ch != CH_COLON) err = 1'b1;
            else st.ctx = CX_ADDR;
         end else if (cur.ctx == CX_SLASH2) begin
            st.only_protocol = 1'b0;
            if (ch != CH_SLASH) begin
               err = 1'b1;
            end else begin
               st.ctx       = CX_VPATH;
               st.path_seen = 1'b1;
               tag          = TAG_PATH;
            end
         end else if (ch == CH_AT) begin
            st.only_protocol = 1'b0;
            // an at-sign opening the task belongs to the task
            if (cur.ctx == CX_TASK && cur.task_empty) begin
               st.task_empty = 1'b0;
               tag           = TAG_TASK;
            end else if (cur.ctx != CX_PROTOCOL && cur.ctx != CX_ADDR) begin
               err = 1'b1;
            end else begin
               st.ctx = CX_ROLE;
            end
         end else if (ch == CH_HASH) begin
            st.only_protocol = 1'b0;
            if (cur.ctx != CX_PROTOCOL && cur.ctx != CX_ADDR) err = 1'b1;
            else st.ctx = CX_HOST;
         end else if (ch == CH_SLASH) begin
            st.only_protocol = 1'b0;
            case (cur.ctx)
               CX_PROTOCOL, CX_ADDR: begin
                  if (is_last) begin
                     err = 1'b1;
                  end else begin
                     st.ctx = CX_SLASH2;
                     tag    = TAG_PATH;
                  end
               end
               CX_VPATH: tag = TAG_PATH;
               CX_HOST:  st.ctx = CX_NODE;
               CX_NODE:  st.ctx = CX_TASK;
               CX_TASK:  st.ctx = CX_END;
               default:  err = 1'b1;
            endcase
         end else if (ch == CH_COLON) begin
            st.only_protocol = 1'b0;
            if (cur.ctx != CX_PROTOCOL || is_last) err = 1'b1;
            else st.ctx = CX_COLON2;
         end else if (ch == CH_SPACE) begin
            st.only_protocol = 1'b0;
         end else begin
            case (cur.ctx)
               CX_PROTOCOL: tag = TAG_PROTOCOL;
               CX_ADDR: begin
                  st.only_protocol = 1'b0;
                  st.ctx           = CX_HOST;
                  tag              = TAG_HOST;
               end
               CX_ROLE: begin
                  st.only_protocol = 1'b0;
                  st.role_seen     = 1'b1;
                  tag              = TAG_ROLE;
               end
               CX_HOST: begin
                  st.only_protocol = 1'b0;
                  tag              = TAG_HOST;
               end
               CX_NODE: begin
                  st.only_protocol = 1'b0;
                  tag              = TAG_NODE;
               end
               CX_TASK: begin
                  st.only_protocol = 1'b0;
                  st.task_empty    = 1'b0;
                  tag              = TAG_TASK;
               end
               CX_VPATH: begin
                  st.only_protocol = 1'b0;
                  tag              = TAG_PATH;
               end
               default: begin
                  st.only_protocol = 1'b0;
                  err              = 1'b1;
               end
            endcase
         end
         if (err) begin
            st.failed = 1'b1;
            tag       = TAG_NONE;
         end
      end

      res.field_tag    = tag;
      res.char_error   = err;
      res.format_valid = 1'b0;
      res.addr_format  = FMT_DEFAULT;
      nxt              = st;
      if (is_last) begin
         if (!st.failed) begin
            res.format_valid = 1'b1;
            if (st.role_seen)          res.addr_format = FMT_ROLE;
            else if (st.path_seen)     res.addr_format = FMT_VPATH;
            else if (st.only_protocol) res.addr_format = FMT_RAW;
            else                       res.addr_format = FMT_DEFAULT;
         end
         nxt = STATE_RESET;
      end
   end

endmodule

// ----- rtl/message_address_char_parser_core.sv -----
// rsp_valid rises after the req transfer passes the input register, then the result register
// throughput: one character per cycle unless rsp_ready stalls the result register;
// the parse context update is a single-cycle loop; input register and result register
// stall independently, so req_ready stays high while a finished result waits unless
// both stages are full. Reset (synchronous, active high) empties both stages and returns
// the parse context to protocol; the context also returns to reset after every last character
module message_address_char_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_field_tag,
   output logic       rsp_char_error,
   output logic       rsp_format_valid,
   output logic [1:0] rsp_addr_format
);
   import macp_pkg::*;

   logic            in_vld_ff, in_vld_in;
   logic [7:0]      ch_ff;
   logic            last_ff;
   logic            out_vld_ff, out_vld_in;
   macp_result_type res_ff, res_in;
   macp_state_type  state_ff, state_in;
   logic            advance;
   logic            req_xfer;

   macp_step u_step (
      .cur     (state_ff),
      .ch      (ch_ff),
      .is_last (last_ff),
      .nxt     (state_in),
      .res     (res_in)
   );

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_vld_in  = req_xfer || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= STATE_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ch_ff   <= req_ch;
         last_ff <= req_is_last;
      end
      if (advance) res_ff <= res_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_field_tag    = res_ff.field_tag;
   assign rsp_char_error   = res_ff.char_error;
   assign rsp_format_valid = res_ff.format_valid;
   assign rsp_addr_format  = res_ff.addr_format;

   a_ctx_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.ctx))
      else $error("parse context not one-hot");

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      advance && last_ff |=> state_ff == STATE_RESET)
      else $error("context not cleared after last character");

   a_err_no_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_error |-> rsp_field_tag == TAG_NONE && !rsp_format_valid)
      else $error("errored transfer carries a tag or a valid format");

   a_fmt_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_format_valid |-> rsp_addr_format == FMT_DEFAULT)
      else $error("format reported without a clean parse");

   a_failed_silent: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.failed |=> res_ff.field_tag == TAG_NONE && !res_ff.char_error)
      else $error("character after an error was parsed");

endmodule
